@@ design/pcbe_pkg.sv @@
// Package with widths, codes and the BCH check-column function of the pager encoder.
`timescale 1ns / 1ps
`default_nettype none

package pcbe_pkg;

   // Field widths.
   localparam int unsigned ADDR_WIDTH     = 21;
   localparam int unsigned PAYLOAD_WIDTH  = 20;
   localparam int unsigned FUNC_WIDTH     = 2;
   localparam int unsigned CODEWORD_WIDTH = 32;
   localparam int unsigned DATA_BITS      = 21;
   localparam int unsigned CHECK_BITS     = 10;
   localparam int unsigned REQ_DATA_WIDTH = 48;

   // Frame-position bits dropped from the receiver address.
   localparam int unsigned ADDR_DROP_BITS = 3;

   // Generator polynomial of the BCH(31,21) code.
   localparam logic [CHECK_BITS:0] GEN_POLY = 11'h769;

   // Codeword kinds carried on the request tuser.
   typedef enum logic {
      OP_ADDRESS = 1'b0,
      OP_MESSAGE = 1'b1
   } op_type;

   // Check bits contributed by one data bit: remainder of x^(pos+10) modulo the generator.
   // Only ever called with constant arguments, so it is resolved at elaboration.
   function automatic logic [CHECK_BITS-1:0] bch_column(input int unsigned pos);
      logic [DATA_BITS+CHECK_BITS-1:0] rem;
      rem = (DATA_BITS+CHECK_BITS)'(1) << (pos + CHECK_BITS);
      for (int k = DATA_BITS + CHECK_BITS - 1; k >= int'(CHECK_BITS); k--) begin
         if (rem[k]) begin
            rem = rem ^ ((DATA_BITS+CHECK_BITS)'(GEN_POLY) << (k - int'(CHECK_BITS)));
         end
      end
      return rem[CHECK_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/pcbe_codeword_encoder.sv @@
// Combinational codeword builder: data field selection, BCH check bits and even parity.
`timescale 1ns / 1ps
`default_nettype none

module pcbe_codeword_encoder
   import pcbe_pkg::*;
(
   input  var op_type                     op,
   input  var logic [ADDR_WIDTH-1:0]      receiver_address,
   input  var logic [PAYLOAD_WIDTH-1:0]   payload_bits,
   input  var logic [FUNC_WIDTH-1:0]      func_code,
   output var logic [CODEWORD_WIDTH-1:0]  codeword
);

   logic [DATA_BITS-1:0]  data_word;
   logic [CHECK_BITS-1:0] check_bits;
   logic [CHECK_BITS-1:0] column_terms [DATA_BITS];

   // Flag bit followed by either the address field and function code or the payload.
   always_comb begin
      if (op == OP_MESSAGE) begin
         data_word = {1'b1, payload_bits};
      end else begin
         data_word = {1'b0, receiver_address[ADDR_WIDTH-1:ADDR_DROP_BITS], func_code};
      end
   end

   // The remainder is linear in the data bits: each set bit adds its fixed column.
   for (genvar i = 0; i < DATA_BITS; i++) begin : g_column
      localparam logic [CHECK_BITS-1:0] COLUMN = bch_column(i);
      assign column_terms[i] = data_word[i] ? COLUMN : '0;
   end

   // XOR tree over the selected columns.
   always_comb begin
      check_bits = '0;
      for (int i = 0; i < DATA_BITS; i++) begin
         check_bits = check_bits ^ column_terms[i];
      end
   end

   // Even parity over the 31 code bits closes the word.
   always_comb begin
      codeword = {data_word, check_bits, 1'b0};
      codeword[0] = ^{data_word, check_bits};
   end

endmodule

`default_nettype wire

@@ design/pager_codeword_bch_encoder.sv @@
// Top level of the pager codeword BCH encoder: request register, encoder and response register.
//
// Usage:
// - Request channel (req_*): one transaction per codeword. req_tuser selects the kind:
//   0 builds an address codeword from req_tdata[20:0], 1 a message codeword from
//   req_tdata[40:21].
// - Response channel (rsp_*): exactly one 32-bit codeword per request, in request order,
//   bit 31 transmitted first.
// - csr_wen / csr_wdata write the 2-bit function code used in address codewords. Write it
//   only while no request is in flight.
// - A request accepted into the request register is encoded there and moves on into the
//   response register, which drives rsp_*, as soon as that register is free.
// - Throughput: one codeword per cycle while rsp_tready stays high; the encoder is a single
//   XOR network between the request register and the response register.
// - Reset clears both pipeline stages and sets the function code to 0.
// - While the receiver holds rsp_tready low, the response holds and the request register
//   keeps taking one more transaction before req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module pager_codeword_bch_encoder
   import pcbe_pkg::*;
(
   input  var logic                        clock,
   input  var logic                        reset,
   // Request channel.
   input  var logic                        req_tvalid,
   output var logic                        req_tready,
   input  var logic [REQ_DATA_WIDTH-1:0]   req_tdata,  // [20:0] receiver_address, [40:21] payload_bits, rest zero
   input  var logic                        req_tuser,  // [0] operation
   // Response channel.
   output var logic                        rsp_tvalid,
   input  var logic                        rsp_tready,
   output var logic [CODEWORD_WIDTH-1:0]   rsp_tdata,  // [31:0] codeword
   // Function code register.
   input  var logic                        csr_wen,
   input  var logic [FUNC_WIDTH-1:0]       csr_wdata
);

   logic                        func_code_wen;
   logic [FUNC_WIDTH-1:0]       func_code_ff;
   logic [FUNC_WIDTH-1:0]       func_code_in;

   logic                        req_valid_ff;
   logic                        req_valid_in;
   logic                        req_load;
   op_type                      req_op_ff;
   logic [ADDR_WIDTH-1:0]       req_addr_ff;
   logic [PAYLOAD_WIDTH-1:0]    req_payload_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_load;
   logic [CODEWORD_WIDTH-1:0]   rsp_word_ff;
   logic [CODEWORD_WIDTH-1:0]   encoded_word;

   // Function code register.
   assign func_code_wen = csr_wen;
   assign func_code_in  = csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         func_code_ff <= '0;
      end else if (func_code_wen) begin
         func_code_ff <= func_code_in;
      end
   end

   // Pipeline advance: each stage moves when the stage after it is free or draining.
   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !req_valid_ff || rsp_load;
   assign req_load     = req_tvalid && req_tready;
   assign req_valid_in = req_tvalid || (req_valid_ff && !rsp_load);
   assign rsp_valid_in = req_valid_ff || (rsp_valid_ff && !rsp_tready);

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_op_ff      <= op_type'(req_tuser);
         req_addr_ff    <= req_tdata[ADDR_WIDTH-1:0];
         req_payload_ff <= req_tdata[ADDR_WIDTH+PAYLOAD_WIDTH-1:ADDR_WIDTH];
      end
   end

   // Codeword construction.
   pcbe_codeword_encoder u_encoder (
      .op               (req_op_ff),
      .receiver_address (req_addr_ff),
      .payload_bits     (req_payload_ff),
      .func_code        (func_code_ff),
      .codeword         (encoded_word)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && req_valid_ff) begin
         rsp_word_ff <= encoded_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

`default_nettype wire

@@ design/pcbe_checker.sv @@
// Port-level checker for the pager codeword encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcbe_checker
   import pcbe_pkg::*;
(
   input  var logic                        clock,
   input  var logic                        reset,
   input  var logic                        req_tvalid,
   input  var logic                        req_tready,
   input  var logic                        rsp_tvalid,
   input  var logic                        rsp_tready,
   input  var logic [CODEWORD_WIDTH-1:0]   rsp_tdata
);

   // A stalled response holds its codeword.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Every codeword delivered has even parity over all 32 bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (^rsp_tdata) == 1'b0)
      else $error("codeword parity is odd");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A response cannot appear after an empty output unless a request was accepted
   // and has passed through the request register.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) ##1 !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared without a request");

endmodule

bind pager_codeword_bch_encoder pcbe_checker u_pcbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ test/pager_codeword_bch_encoder_test.sv @@
// Self-checking testbench for the pager codeword BCH encoder with a scoreboard class.
`timescale 1ns / 1ps

module pager_codeword_bch_encoder_test;
   import pcbe_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASE_ITEMS = 210;
   localparam int unsigned PHASE_COUNT = 8;

   // Predicts codewords for accepted requests and checks the responses in order.
   class bch_scoreboard;
      logic [CODEWORD_WIDTH-1:0] pending_codewords[$];
      logic [FUNC_WIDTH-1:0]     func_code;
      int                        failures;

      function new();
         func_code = '0;
         failures  = 0;
      endfunction

      // Builds the data field, divides by the generator and adds even parity.
      function logic [CODEWORD_WIDTH-1:0] encode(op_type op,
                                                 logic [ADDR_WIDTH-1:0] addr,
                                                 logic [PAYLOAD_WIDTH-1:0] payload);
         logic [CODEWORD_WIDTH-1:0] word;
         logic [CODEWORD_WIDTH-1:0] rem;
         if (op == OP_MESSAGE) begin
            word = {1'b1, payload, 11'b0};
         end else begin
            word = {1'b0, addr[ADDR_WIDTH-1:ADDR_DROP_BITS], func_code, 11'b0};
         end
         rem = word;
         for (int i = CODEWORD_WIDTH - 1; i > int'(CHECK_BITS); i--) begin
            if (rem[i]) begin
               rem = rem ^ (CODEWORD_WIDTH'(GEN_POLY) << (i - int'(CHECK_BITS)));
            end
         end
         word[CHECK_BITS:1] = rem[CHECK_BITS:1];
         word[0] = ^word[CODEWORD_WIDTH-1:1];
         return word;
      endfunction

      function void note_request(op_type op, logic [ADDR_WIDTH-1:0] addr,
                                 logic [PAYLOAD_WIDTH-1:0] payload);
         pending_codewords.push_back(encode(op, addr, payload));
      endfunction

      function void check_codeword(logic [CODEWORD_WIDTH-1:0] actual);
         logic [CODEWORD_WIDTH-1:0] predicted;
         if (pending_codewords.size() == 0) begin
            $display("%0t: unexpected codeword, expected none, actual %h", $time, actual);
            failures++;
         end else begin
            predicted = pending_codewords.pop_front();
            if (actual !== predicted) begin
               $display("%0t: codeword mismatch, expected %h, actual %h",
                        $time, predicted, actual);
               failures++;
            end
         end
      endfunction
   endclass

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata  = '0;  // [20:0] receiver_address, [40:21] payload_bits
   logic                        req_tuser  = 1'b0;  // [0] operation
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [CODEWORD_WIDTH-1:0]   rsp_tdata;  // [31:0] codeword
   logic                        csr_wen    = 1'b0;
   logic [FUNC_WIDTH-1:0]       csr_wdata  = '0;

   bch_scoreboard sb;
   logic          steady = 1'b0;
   int unsigned   stall_cycles = 0;

   pager_codeword_bch_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   // Monitor: record accepted requests and check accepted responses.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(op_type'(req_tuser), req_tdata[ADDR_WIDTH-1:0],
                            req_tdata[ADDR_WIDTH+PAYLOAD_WIDTH-1:ADDR_WIDTH]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_codeword(rsp_tdata);
         end
      end
   end

   // Watchdog: end the run when no transaction completes for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL pager_codeword_bch_encoder");
            $finish;
         end
      end
   end

   // Offers one request, with an occasional gap first, and returns at its acceptance.
   task automatic send_request(input op_type op, input logic [ADDR_WIDTH-1:0] addr,
                               input logic [PAYLOAD_WIDTH-1:0] payload);
      int gap;
      if (!steady && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_WIDTH-ADDR_WIDTH-PAYLOAD_WIDTH){1'b0}}, payload, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds off the sender until every predicted codeword has come back.
   task automatic wait_for_codewords();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_codewords.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_function_code(input logic [FUNC_WIDTH-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.func_code = value;
   endtask

   // Random field values, biased now and then toward the extremes.
   function automatic logic [ADDR_WIDTH-1:0] pick_address();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return ADDR_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [PAYLOAD_WIDTH-1:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PAYLOAD_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      logic [FUNC_WIDTH-1:0] code;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests with the function code still at its reset value.
      send_request(OP_ADDRESS, 21'h000000, 20'h00000);
      send_request(OP_ADDRESS, 21'h1FFFFF, 20'hFFFFF);
      send_request(OP_ADDRESS, 21'h000007, 20'h00000);
      send_request(OP_ADDRESS, 21'h000008, 20'h00000);
      send_request(OP_ADDRESS, 21'h100000, 20'h00000);
      send_request(OP_ADDRESS, 21'h0AAAAA, 20'h55555);
      send_request(OP_MESSAGE, 21'h000000, 20'h00000);
      send_request(OP_MESSAGE, 21'h1FFFFF, 20'hFFFFF);
      send_request(OP_MESSAGE, 21'h000000, 20'h80000);
      send_request(OP_MESSAGE, 21'h000000, 20'h00001);
      send_request(OP_MESSAGE, 21'h155555, 20'hAAAAA);
      send_request(OP_MESSAGE, 21'h0AAAAA, 20'h55555);
      wait_for_codewords();

      // All-zero and all-one address cases, plus one message, under every other function code.
      for (int fc = 3; fc >= 1; fc--) begin
         write_function_code(FUNC_WIDTH'(fc));
         send_request(OP_ADDRESS, 21'h000000, 20'hFFFFF);
         send_request(OP_ADDRESS, 21'h1FFFFF, 20'h00000);
         send_request(OP_MESSAGE, 21'h1FFFFF, 20'h12345);
         wait_for_codewords();
      end

      // Random phases, each after a new function code write; one phase runs without stalls.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: code = 2'd0;
            1: code = 2'd3;
            2: code = 2'd1;
            3: code = 2'd2;
            default: code = FUNC_WIDTH'($urandom);
         endcase
         write_function_code(code);
         steady = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(op_type'($urandom_range(0, 1)), pick_address(), pick_payload());
         end
         wait_for_codewords();
         steady = 1'b0;
      end

      repeat (5) @(posedge clock);
      if (sb.failures == 0 && sb.pending_codewords.size() == 0) begin
         $display("PASS pager_codeword_bch_encoder");
      end else begin
         $display("FAIL pager_codeword_bch_encoder");
      end
      $finish;
   end

endmodule
